FILE: rtl/gfc_pkg.sv
`timescale 1ns / 1ps
// gfc_pkg: widths, constants, register indexes and shared types of the
// geofence checker. No dependencies.
package gfc_pkg;

  localparam int BYTE_W  = 8;
  localparam int LAT_W   = 30;
  localparam int LON_W   = 31;
  localparam int DIST_W  = 62;
  localparam int POS_W   = 10;
  localparam int CFG_W   = 62;
  localparam int CIDX_W  = 2;

  localparam int LAT_DEG_W = 7;
  localparam int LON_DEG_W = 10;
  localparam int MIN_W     = 20;

  // register indexes
  localparam logic [CIDX_W-1:0] REG_HOME_LAT   = 2'd0;
  localparam logic [CIDX_W-1:0] REG_HOME_LON   = 2'd1;
  localparam logic [CIDX_W-1:0] REG_ALARM_DIST = 2'd2;
  localparam logic [CIDX_W-1:0] REG_POS_OFFSET = 2'd3;

  // register reset values
  localparam logic [LAT_W-1:0]  HOME_LAT_RST   = 30'd490389554;
  localparam logic [LON_W-1:0]  HOME_LON_RST   = 31'd20712599;
  localparam logic [DIST_W-1:0] ALARM_DIST_RST = 62'd411588480;
  localparam logic [POS_W-1:0]  POS_OFFSET_RST = 10'd18;

  // framing characters
  localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;
  localparam logic [39:0]       MARKER     = 40'h4F4B2A3335;
  localparam int                MARKER_MIN_INDEX = 4;

  // field layout relative to the position offset
  localparam int LAT_DEG_FIRST   = 0;
  localparam int LAT_DEG_LAST    = 1;
  localparam int LAT_MIN_FIRST   = 2;
  localparam int LAT_MIN_A_LAST  = 3;
  localparam int LAT_MIN_B_FIRST = 5;
  localparam int LAT_MIN_LAST    = 8;
  localparam int LON_DEG_FIRST   = 13;
  localparam int LON_DEG_LAST    = 15;
  localparam int LON_MIN_FIRST   = 16;
  localparam int LON_MIN_A_LAST  = 17;
  localparam int LON_MIN_B_FIRST = 19;
  localparam int LON_MIN_LAST    = 22;

  // fixed point scaling
  localparam logic [23:0] E7_SCALE   = 24'd10000000;
  localparam logic [9:0]  MIN_SCALE  = 10'd1000;
  localparam logic [4:0]  ROUND_BIAS = 5'd30;
  localparam logic [31:0] DIV15_RECIP = 32'h8888_8889;
  localparam int          DIV15_SHIFT = 35;
  localparam logic [LAT_W-1:0] LAT_MAX = 30'd999999999;
  localparam logic [LON_W-1:0] LON_MAX = 31'd1999999999;

  typedef struct packed {
    logic [LAT_DEG_W-1:0] lat_deg;
    logic [MIN_W-1:0]     lat_min;
    logic [LON_DEG_W-1:0] lon_deg;
    logic [MIN_W-1:0]     lon_min;
    logic                 err;
  } gfc_snap_t;

  typedef struct packed {
    logic [LAT_W-1:0]  home_lat;
    logic [LON_W-1:0]  home_lon;
    logic [DIST_W-1:0] alarm_dist;
  } gfc_cfg_t;

endpackage

FILE: rtl/gfc_if.sv
`timescale 1ns / 1ps
// gfc_rx_if and gfc_pos_if: valid/ready channels of the geofence checker.
// Depends on gfc_pkg.
interface gfc_rx_if;
  logic                         valid;
  logic                         ready;
  logic [gfc_pkg::BYTE_W-1:0]   rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface gfc_pos_if;
  logic                        valid;
  logic                        ready;
  logic [gfc_pkg::LAT_W-1:0]   latitude_e7;
  logic [gfc_pkg::LON_W-1:0]   longitude_e7;
  logic                        outside_area;
  logic                        field_error;

  modport source (output valid, output latitude_e7, output longitude_e7,
                  output outside_area, output field_error, input ready);
  modport sink (input valid, input latitude_e7, input longitude_e7,
                input outside_area, input field_error, output ready);
endinterface

FILE: rtl/gfc_result_pipe.sv
`timescale 1ns / 1ps
// gfc_result_pipe: elastic pipeline from a captured frame to a position
// request. Depends on gfc_pkg and gfc_pos_if.
module gfc_result_pipe (
  input  logic               clk,
  input  logic               rst,
  input  logic               snap_valid,
  output logic               snap_ready,
  input  gfc_pkg::gfc_snap_t snap,
  input  gfc_pkg::gfc_cfg_t  cfg,
  gfc_pos_if.source          pos
);

  logic v1, v2, v3, v4, v5, v6, v7;
  logic ce1, ce2, ce3, ce4, ce5, ce6, ce7;

  assign ce7 = !v7 || pos.ready;
  assign ce6 = !v6 || ce7;
  assign ce5 = !v5 || ce6;
  assign ce4 = !v4 || ce5;
  assign ce3 = !v3 || ce4;
  assign ce2 = !v2 || ce3;
  assign ce1 = !v1 || ce2;
  assign snap_ready = ce1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else begin
      if (ce1) v1 <= snap_valid;
      if (ce2) v2 <= v1;
      if (ce3) v3 <= v2;
      if (ce4) v4 <= v3;
      if (ce5) v5 <= v4;
      if (ce6) v6 <= v5;
      if (ce7) v7 <= v6;
    end
  end

  // stage 1: captured fields
  gfc_pkg::gfc_snap_t s1;

  always_ff @(posedge clk) begin
    if (ce1) s1 <= snap;
  end

  // stage 2: degree scaling and minute scaling
  logic [30:0] s2_lat_degs;
  logic [33:0] s2_lon_degs;
  logic [29:0] s2_lat_x;
  logic [29:0] s2_lon_x;
  logic        s2_err;

  always_ff @(posedge clk) begin
    if (ce2) begin
      s2_lat_degs <= 31'(s1.lat_deg) * 31'(gfc_pkg::E7_SCALE);
      s2_lon_degs <= 34'(s1.lon_deg) * 34'(gfc_pkg::E7_SCALE);
      s2_lat_x    <= 30'(s1.lat_min) * 30'(gfc_pkg::MIN_SCALE) + 30'(gfc_pkg::ROUND_BIAS);
      s2_lon_x    <= 30'(s1.lon_min) * 30'(gfc_pkg::MIN_SCALE) + 30'(gfc_pkg::ROUND_BIAS);
      s2_err      <= s1.err;
    end
  end

  // stage 3: divide by 60 as shift by 2 and reciprocal multiply by 1/15
  logic [59:0] lat_prod;
  logic [59:0] lon_prod;
  logic [30:0] s3_lat_degs;
  logic [33:0] s3_lon_degs;
  logic [24:0] s3_lat_q;
  logic [24:0] s3_lon_q;
  logic        s3_err;

  assign lat_prod = 60'(s2_lat_x[29:2]) * 60'(gfc_pkg::DIV15_RECIP);
  assign lon_prod = 60'(s2_lon_x[29:2]) * 60'(gfc_pkg::DIV15_RECIP);

  always_ff @(posedge clk) begin
    if (ce3) begin
      s3_lat_degs <= s2_lat_degs;
      s3_lon_degs <= s2_lon_degs;
      s3_lat_q    <= lat_prod[gfc_pkg::DIV15_SHIFT +: 25];
      s3_lon_q    <= lon_prod[gfc_pkg::DIV15_SHIFT +: 25];
      s3_err      <= s2_err;
    end
  end

  // stage 4: sum and saturate
  logic [34:0] lat_sum;
  logic [34:0] lon_sum;
  logic [gfc_pkg::LAT_W-1:0] s4_lat;
  logic [gfc_pkg::LON_W-1:0] s4_lon;
  logic                      s4_err;

  assign lat_sum = 35'(s3_lat_degs) + 35'(s3_lat_q);
  assign lon_sum = 35'(s3_lon_degs) + 35'(s3_lon_q);

  always_ff @(posedge clk) begin
    if (ce4) begin
      s4_lat <= (lat_sum > 35'(gfc_pkg::LAT_MAX)) ? gfc_pkg::LAT_MAX
                                                 : lat_sum[gfc_pkg::LAT_W-1:0];
      s4_lon <= (lon_sum > 35'(gfc_pkg::LON_MAX)) ? gfc_pkg::LON_MAX
                                                 : lon_sum[gfc_pkg::LON_W-1:0];
      s4_err <= s3_err;
    end
  end

  // stage 5: distance to home on each axis
  logic [gfc_pkg::LAT_W-1:0] s5_lat;
  logic [gfc_pkg::LON_W-1:0] s5_lon;
  logic [gfc_pkg::LAT_W-1:0] s5_dlat;
  logic [gfc_pkg::LON_W-1:0] s5_dlon;
  logic                      s5_err;

  always_ff @(posedge clk) begin
    if (ce5) begin
      s5_lat  <= s4_lat;
      s5_lon  <= s4_lon;
      s5_dlat <= (cfg.home_lat >= s4_lat) ? cfg.home_lat - s4_lat : s4_lat - cfg.home_lat;
      s5_dlon <= (cfg.home_lon >= s4_lon) ? cfg.home_lon - s4_lon : s4_lon - cfg.home_lon;
      s5_err  <= s4_err;
    end
  end

  // stage 6: squares
  logic [gfc_pkg::LAT_W-1:0] s6_lat;
  logic [gfc_pkg::LON_W-1:0] s6_lon;
  logic [59:0]               s6_sq_lat;
  logic [61:0]               s6_sq_lon;
  logic                      s6_err;

  always_ff @(posedge clk) begin
    if (ce6) begin
      s6_lat    <= s5_lat;
      s6_lon    <= s5_lon;
      s6_sq_lat <= 60'(s5_dlat) * 60'(s5_dlat);
      s6_sq_lon <= 62'(s5_dlon) * 62'(s5_dlon);
      s6_err    <= s5_err;
    end
  end

  // stage 7: threshold compare into the output register
  logic [62:0] dist_sum;

  assign dist_sum = 63'(s6_sq_lat) + 63'(s6_sq_lon);

  always_ff @(posedge clk) begin
    if (ce7) begin
      pos.latitude_e7  <= s6_lat;
      pos.longitude_e7 <= s6_lon;
      pos.outside_area <= dist_sum >= 63'(cfg.alarm_dist);
      pos.field_error  <= s6_err;
    end
  end

  assign pos.valid = v7;

endmodule

FILE: rtl/gps_frame_geofence_checker_top.sv
`timescale 1ns / 1ps
// One received byte is taken per clock while byte ready is high. Line feeds are
// dropped; other bytes are counted from the last OK*35 marker and the digit fields
// are accumulated as they pass. Each marker after the first starts a seven-stage
// result pipeline (minute scaling, reciprocal divide, saturate, axis distance,
// squares, threshold compare) whose output register presents the position request.
// Byte ready falls only while that pipeline is full behind a stalled output.
// Configuration writes take effect on the next clock edge.
// Depends on gfc_pkg, gfc_rx_if, gfc_pos_if and gfc_result_pipe.
module gps_frame_geofence_checker_top #(
  parameter int FRAME_LIMIT = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  gfc_rx_if.sink                        rx,
  gfc_pos_if.source                     pos,
  input  logic                          cfg_we,
  input  logic [gfc_pkg::CIDX_W-1:0]    cfg_index,
  input  logic [gfc_pkg::CFG_W-1:0]     cfg_data
);

  localparam int IDX_W = $clog2(FRAME_LIMIT);
  localparam int CMP_W = (IDX_W > gfc_pkg::POS_W) ? IDX_W : gfc_pkg::POS_W;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(FRAME_LIMIT - 1);

  // configuration registers
  gfc_pkg::gfc_cfg_t cfg;
  logic [gfc_pkg::POS_W-1:0] position_offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.home_lat    <= gfc_pkg::HOME_LAT_RST;
      cfg.home_lon    <= gfc_pkg::HOME_LON_RST;
      cfg.alarm_dist  <= gfc_pkg::ALARM_DIST_RST;
      position_offset <= gfc_pkg::POS_OFFSET_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        gfc_pkg::REG_HOME_LAT:   cfg.home_lat    <= cfg_data[gfc_pkg::LAT_W-1:0];
        gfc_pkg::REG_HOME_LON:   cfg.home_lon    <= cfg_data[gfc_pkg::LON_W-1:0];
        gfc_pkg::REG_ALARM_DIST: cfg.alarm_dist  <= cfg_data[gfc_pkg::DIST_W-1:0];
        gfc_pkg::REG_POS_OFFSET: position_offset <= cfg_data[gfc_pkg::POS_W-1:0];
        default: ;
      endcase
    end
  end

  // frame state
  logic [IDX_W-1:0]              byte_index;
  logic [39:0]                   marker_history;
  logic                          first_marker_seen;
  logic [gfc_pkg::LAT_DEG_W-1:0] lat_deg;
  logic [gfc_pkg::MIN_W-1:0]     lat_min;
  logic [gfc_pkg::LON_DEG_W-1:0] lon_deg;
  logic [gfc_pkg::MIN_W-1:0]     lon_min;
  logic                          digit_err;

  logic                          accept;
  logic                          take;
  logic                          snap_ready;
  logic                          snap_valid;
  gfc_pkg::gfc_snap_t            snap;

  logic [gfc_pkg::BYTE_W-1:0]    c;
  logic                          is_digit;
  logic [3:0]                    d;
  logic [CMP_W-1:0]              bi_ext;
  logic [CMP_W-1:0]              off_ext;
  logic [CMP_W-1:0]              k;
  logic                          in_field;
  logic                          at_lat_deg, at_lat_min, at_lon_deg, at_lon_min;
  logic [39:0]                   hist_next;
  logic                          marker;

  logic [gfc_pkg::LAT_DEG_W-1:0] lat_deg_next;
  logic [gfc_pkg::MIN_W-1:0]     lat_min_next;
  logic [gfc_pkg::LON_DEG_W-1:0] lon_deg_next;
  logic [gfc_pkg::MIN_W-1:0]     lon_min_next;
  logic                          digit_err_next;

  assign c        = rx.rx_byte;
  assign accept   = rx.valid && rx.ready;
  assign take     = accept && (c != gfc_pkg::CHAR_LF);
  assign is_digit = (c >= gfc_pkg::CHAR_ZERO) && (c <= gfc_pkg::CHAR_NINE);
  assign d        = is_digit ? c[3:0] : 4'd0;

  assign bi_ext   = CMP_W'(byte_index);
  assign off_ext  = CMP_W'(position_offset);
  assign in_field = bi_ext >= off_ext;
  assign k        = bi_ext - off_ext;

  assign at_lat_deg = in_field && k <= CMP_W'(gfc_pkg::LAT_DEG_LAST);
  assign at_lat_min = in_field &&
                      ((k >= CMP_W'(gfc_pkg::LAT_MIN_FIRST) &&
                        k <= CMP_W'(gfc_pkg::LAT_MIN_A_LAST)) ||
                       (k >= CMP_W'(gfc_pkg::LAT_MIN_B_FIRST) &&
                        k <= CMP_W'(gfc_pkg::LAT_MIN_LAST)));
  assign at_lon_deg = in_field && k >= CMP_W'(gfc_pkg::LON_DEG_FIRST) &&
                      k <= CMP_W'(gfc_pkg::LON_DEG_LAST);
  assign at_lon_min = in_field &&
                      ((k >= CMP_W'(gfc_pkg::LON_MIN_FIRST) &&
                        k <= CMP_W'(gfc_pkg::LON_MIN_A_LAST)) ||
                       (k >= CMP_W'(gfc_pkg::LON_MIN_B_FIRST) &&
                        k <= CMP_W'(gfc_pkg::LON_MIN_LAST)));

  assign hist_next = {marker_history[31:0], c};
  assign marker    = (byte_index >= IDX_W'(gfc_pkg::MARKER_MIN_INDEX)) &&
                     (hist_next == gfc_pkg::MARKER);

  // digit accumulate, first position of each field restarts it
  always_comb begin
    lat_deg_next   = lat_deg;
    lat_min_next   = lat_min;
    lon_deg_next   = lon_deg;
    lon_min_next   = lon_min;
    digit_err_next = digit_err;
    if (at_lat_deg) begin
      if (k == CMP_W'(gfc_pkg::LAT_DEG_FIRST)) begin
        lat_deg_next = gfc_pkg::LAT_DEG_W'(d);
      end else begin
        lat_deg_next = gfc_pkg::LAT_DEG_W'({lat_deg, 3'b000} + 10'({lat_deg, 1'b0}) + 10'(d));
      end
    end
    if (at_lat_min) begin
      if (k == CMP_W'(gfc_pkg::LAT_MIN_FIRST)) begin
        lat_min_next = gfc_pkg::MIN_W'(d);
      end else begin
        lat_min_next = gfc_pkg::MIN_W'({lat_min, 3'b000} + 23'({lat_min, 1'b0}) + 23'(d));
      end
    end
    if (at_lon_deg) begin
      if (k == CMP_W'(gfc_pkg::LON_DEG_FIRST)) begin
        lon_deg_next = gfc_pkg::LON_DEG_W'(d);
      end else begin
        lon_deg_next = gfc_pkg::LON_DEG_W'({lon_deg, 3'b000} + 13'({lon_deg, 1'b0}) + 13'(d));
      end
    end
    if (at_lon_min) begin
      if (k == CMP_W'(gfc_pkg::LON_MIN_FIRST)) begin
        lon_min_next = gfc_pkg::MIN_W'(d);
      end else begin
        lon_min_next = gfc_pkg::MIN_W'({lon_min, 3'b000} + 23'({lon_min, 1'b0}) + 23'(d));
      end
    end
    if ((at_lat_deg || at_lat_min || at_lon_deg || at_lon_min) && !is_digit) begin
      digit_err_next = 1'b1;
    end
  end

  assign snap.lat_deg = lat_deg_next;
  assign snap.lat_min = lat_min_next;
  assign snap.lon_deg = lon_deg_next;
  assign snap.lon_min = lon_min_next;
  assign snap.err     = digit_err_next;
  assign snap_valid   = take && marker && first_marker_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index        <= '0;
      marker_history    <= '0;
      first_marker_seen <= 1'b0;
      lat_deg           <= '0;
      lat_min           <= '0;
      lon_deg           <= '0;
      lon_min           <= '0;
      digit_err         <= 1'b0;
    end else if (take) begin
      marker_history <= hist_next;
      if (marker) begin
        byte_index        <= '0;
        first_marker_seen <= 1'b1;
        lat_deg           <= '0;
        lat_min           <= '0;
        lon_deg           <= '0;
        lon_min           <= '0;
        digit_err         <= 1'b0;
      end else begin
        byte_index <= (byte_index >= IDX_LAST) ? '0 : byte_index + IDX_W'(1);
        lat_deg    <= lat_deg_next;
        lat_min    <= lat_min_next;
        lon_deg    <= lon_deg_next;
        lon_min    <= lon_min_next;
        digit_err  <= digit_err_next;
      end
    end
  end

  assign rx.ready = snap_ready;

  gfc_result_pipe u_result_pipe (
    .clk        (clk),
    .rst        (rst),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap       (snap),
    .cfg        (cfg),
    .pos        (pos)
  );

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for gps_frame_geofence_checker_top. GGA-like frames are decoded
// by a local predictor and each position request is checked field by field.
// Depends on gfc_pkg, gfc_rx_if, gfc_pos_if and the checker RTL.
module tb;

  localparam int FRAME_LIMIT = 1024;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 16;
  localparam int FIELD_SPAN = 23;
  localparam int PHASES = 8;

  typedef logic [gfc_pkg::BYTE_W-1:0] char_t;

  typedef enum int {
    FRAME_RANDOM, FRAME_NINES, FRAME_ZEROS, FRAME_BAD_DIGIT,
    FRAME_SHORT, FRAME_NOISE
  } frame_kind_t;

  typedef struct packed {
    logic [gfc_pkg::LAT_W-1:0] lat;
    logic [gfc_pkg::LON_W-1:0] lon;
    logic                      outside;
    logic                      err;
  } position_t;

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       cfg_we;
  logic [gfc_pkg::CIDX_W-1:0] cfg_index;
  logic [gfc_pkg::CFG_W-1:0]  cfg_data;

  gfc_rx_if  rx_ch();
  gfc_pos_if pos_ch();

  gps_frame_geofence_checker_top #(.FRAME_LIMIT(FRAME_LIMIT)) u_top (
    .clk(clk),
    .rst(rst),
    .rx(rx_ch),
    .pos(pos_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // geofence settings as last written
  logic [gfc_pkg::LAT_W-1:0]  home_lat;
  logic [gfc_pkg::LON_W-1:0]  home_lon;
  logic [gfc_pkg::DIST_W-1:0] alarm_sq;
  logic [gfc_pkg::POS_W-1:0]  field_offset;

  // frame decoder state
  int unsigned                   frame_pos;
  logic [39:0]                   recent_chars;
  bit                            synced;
  logic [gfc_pkg::LAT_DEG_W-1:0] lat_deg_sum;
  logic [gfc_pkg::MIN_W-1:0]     lat_min_sum;
  logic [gfc_pkg::LON_DEG_W-1:0] lon_deg_sum;
  logic [gfc_pkg::MIN_W-1:0]     lon_min_sum;
  bit                            bad_digit;

  char_t     char_queue[$];
  position_t position_queue[$];
  int        chars_queued;
  int        chars_accepted;
  int        mismatches;
  int        idle_cycles;
  int        send_idle_pct;
  int        recv_stall_pct;
  int        send_idle_by_mode[4] = '{0, 49, 0, 28};
  int        recv_stall_by_mode[4] = '{0, 0, 49, 28};

  function automatic int unsigned next_digit(int unsigned acc, bit restart, char_t c);
    int unsigned d;
    d = 0;
    if (c >= gfc_pkg::CHAR_ZERO && c <= gfc_pkg::CHAR_NINE) d = 32'(c - gfc_pkg::CHAR_ZERO);
    else bad_digit = 1'b1;
    return restart ? d : acc * 10 + d;
  endfunction

  function automatic longint unsigned to_e7(longint unsigned deg, longint unsigned mins,
                                            longint unsigned cap);
    longint unsigned v;
    v = deg * 64'd10000000 + (mins * 64'd1000 + 64'd30) / 64'd60;
    return (v > cap) ? cap : v;
  endfunction

  function automatic longint unsigned sq_gap(longint unsigned a, longint unsigned b);
    longint unsigned d;
    d = (a >= b) ? a - b : b - a;
    return d * d;
  endfunction

  task automatic clear_fields();
    lat_deg_sum = '0;
    lat_min_sum = '0;
    lon_deg_sum = '0;
    lon_min_sum = '0;
    bad_digit = 1'b0;
  endtask

  task automatic decode_char(char_t c);
    int unsigned k;
    longint unsigned lat, lon, gap_sq;
    position_t p;
    if (c == gfc_pkg::CHAR_LF) return;
    if (frame_pos >= field_offset) begin
      k = frame_pos - field_offset;
      if (k <= gfc_pkg::LAT_DEG_LAST)
        lat_deg_sum = gfc_pkg::LAT_DEG_W'(next_digit(32'(lat_deg_sum),
                                                     k == gfc_pkg::LAT_DEG_FIRST, c));
      else if (k <= gfc_pkg::LAT_MIN_A_LAST ||
               (k >= gfc_pkg::LAT_MIN_B_FIRST && k <= gfc_pkg::LAT_MIN_LAST))
        lat_min_sum = gfc_pkg::MIN_W'(next_digit(32'(lat_min_sum),
                                                 k == gfc_pkg::LAT_MIN_FIRST, c));
      else if (k >= gfc_pkg::LON_DEG_FIRST && k <= gfc_pkg::LON_DEG_LAST)
        lon_deg_sum = gfc_pkg::LON_DEG_W'(next_digit(32'(lon_deg_sum),
                                                     k == gfc_pkg::LON_DEG_FIRST, c));
      else if ((k >= gfc_pkg::LON_MIN_FIRST && k <= gfc_pkg::LON_MIN_A_LAST) ||
               (k >= gfc_pkg::LON_MIN_B_FIRST && k <= gfc_pkg::LON_MIN_LAST))
        lon_min_sum = gfc_pkg::MIN_W'(next_digit(32'(lon_min_sum),
                                                 k == gfc_pkg::LON_MIN_FIRST, c));
    end
    recent_chars = {recent_chars[31:0], c};
    if (frame_pos >= gfc_pkg::MARKER_MIN_INDEX && recent_chars == gfc_pkg::MARKER) begin
      frame_pos = 0;
      if (synced) begin
        lat = to_e7(64'(lat_deg_sum), 64'(lat_min_sum), 64'(gfc_pkg::LAT_MAX));
        lon = to_e7(64'(lon_deg_sum), 64'(lon_min_sum), 64'(gfc_pkg::LON_MAX));
        gap_sq = sq_gap(64'(home_lat), lat) + sq_gap(64'(home_lon), lon);
        p.lat = gfc_pkg::LAT_W'(lat);
        p.lon = gfc_pkg::LON_W'(lon);
        p.outside = (gap_sq >= 64'(alarm_sq));
        p.err = bad_digit;
        position_queue.push_back(p);
      end
      synced = 1'b1;
      clear_fields();
    end else if (frame_pos >= FRAME_LIMIT - 1) begin
      frame_pos = 0;
    end else begin
      frame_pos++;
    end
  endtask

  task automatic queue_char(char_t c, int lf_pct);
    if ($urandom_range(99) < lf_pct) begin
      char_queue.push_back(gfc_pkg::CHAR_LF);
      chars_queued++;
    end
    char_queue.push_back(c);
    chars_queued++;
  endtask

  task automatic queue_marker(int lf_pct, int last_byte);
    for (int i = 4; i >= last_byte; i--) queue_char(gfc_pkg::MARKER[i*8 +: 8], lf_pct);
  endtask

  function automatic char_t filler();
    return char_t'($urandom_range(32, 126));
  endfunction

  function automatic char_t field_char(frame_kind_t kind, int k, bit force_bad);
    char_t c;
    if (k == gfc_pkg::LAT_MIN_A_LAST + 1 || k == gfc_pkg::LON_MIN_A_LAST + 1) return ".";
    if (k > gfc_pkg::LAT_MIN_LAST && k < gfc_pkg::LON_DEG_FIRST) return ",";
    case (kind)
      FRAME_NINES: return gfc_pkg::CHAR_NINE;
      FRAME_ZEROS: return gfc_pkg::CHAR_ZERO;
      default: begin
        if (force_bad || (kind == FRAME_BAD_DIGIT && $urandom_range(9) == 0)) begin
          do c = char_t'($urandom_range(255));
          while ((c >= gfc_pkg::CHAR_ZERO && c <= gfc_pkg::CHAR_NINE) ||
                 c == gfc_pkg::CHAR_LF);
          return c;
        end
        return gfc_pkg::CHAR_ZERO + char_t'($urandom_range(9));
      end
    endcase
  endfunction

  task automatic add_frame(frame_kind_t kind, int lf_pct);
    int body, cut, bad_k;
    cut = FIELD_SPAN;
    bad_k = $urandom_range(1) ? $urandom_range(0, gfc_pkg::LAT_MIN_A_LAST)
                              : $urandom_range(gfc_pkg::LON_DEG_FIRST,
                                               gfc_pkg::LON_MIN_A_LAST);
    if (kind == FRAME_NOISE) begin
      body = $urandom_range(1, 40);
      for (int i = 0; i < body; i++) queue_char(char_t'($urandom_range(255)), 0);
      // broken marker
      if ($urandom_range(1)) begin
        queue_marker(0, 1);
        queue_char("!", 0);
      end
    end else begin
      if (kind == FRAME_SHORT) cut = $urandom_range(0, FIELD_SPAN - 1);
      for (int i = 0; i < field_offset; i++) queue_char(filler(), lf_pct);
      for (int k = 0; k < cut; k++)
        queue_char(field_char(kind, k, kind == FRAME_BAD_DIGIT && k == bad_k), lf_pct);
      repeat ($urandom_range(0, 6)) queue_char(filler(), lf_pct);
    end
    queue_marker(lf_pct, 0);
  endtask

  task automatic wait_for_results();
    while (chars_accepted != chars_queued || position_queue.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [gfc_pkg::CIDX_W-1:0] idx,
                           logic [gfc_pkg::CFG_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      gfc_pkg::REG_HOME_LAT:   home_lat = gfc_pkg::LAT_W'(value);
      gfc_pkg::REG_HOME_LON:   home_lon = gfc_pkg::LON_W'(value);
      gfc_pkg::REG_ALARM_DIST: alarm_sq = gfc_pkg::DIST_W'(value);
      gfc_pkg::REG_POS_OFFSET: field_offset = gfc_pkg::POS_W'(value);
      default: ;
    endcase
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      rx_ch.valid <= 1'b0;
    end else begin
      if (rx_ch.valid && rx_ch.ready) begin
        decode_char(rx_ch.rx_byte);
        chars_accepted++;
      end
      if (!rx_ch.valid || rx_ch.ready) begin
        if (char_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          rx_ch.valid <= 1'b1;
          rx_ch.rx_byte <= char_queue.pop_front();
        end else begin
          rx_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    position_t want;
    if (rst) begin
      pos_ch.ready <= 1'b0;
    end else begin
      if (pos_ch.valid && pos_ch.ready) begin
        if (position_queue.size() == 0) begin
          $display("%0t unexpected position request lat %0d lon %0d", $time,
                   pos_ch.latitude_e7, pos_ch.longitude_e7);
          mismatches++;
        end else begin
          want = position_queue.pop_front();
          if (pos_ch.latitude_e7 !== want.lat) begin
            $display("%0t latitude_e7 exp %0d got %0d", $time, want.lat,
                     pos_ch.latitude_e7);
            mismatches++;
          end
          if (pos_ch.longitude_e7 !== want.lon) begin
            $display("%0t longitude_e7 exp %0d got %0d", $time, want.lon,
                     pos_ch.longitude_e7);
            mismatches++;
          end
          if (pos_ch.outside_area !== want.outside) begin
            $display("%0t outside_area exp %0b got %0b", $time, want.outside,
                     pos_ch.outside_area);
            mismatches++;
          end
          if (pos_ch.field_error !== want.err) begin
            $display("%0t field_error exp %0b got %0b", $time, want.err,
                     pos_ch.field_error);
            mismatches++;
          end
        end
      end
      pos_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (rx_ch.valid && rx_ch.ready) || (pos_ch.valid && pos_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("gps_frame_geofence_checker_top test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [gfc_pkg::LAT_W-1:0]  lat_cfg;
    logic [gfc_pkg::LON_W-1:0]  lon_cfg;
    logic [gfc_pkg::DIST_W-1:0] alarm_cfg;
    logic [gfc_pkg::POS_W-1:0]  offset_cfg;
    int                         start, frames, pick;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    rx_ch.valid = 1'b0;
    rx_ch.rx_byte = '0;
    pos_ch.ready = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    chars_queued = 0;
    chars_accepted = 0;
    mismatches = 0;
    idle_cycles = 0;
    home_lat = gfc_pkg::HOME_LAT_RST;
    home_lon = gfc_pkg::HOME_LON_RST;
    alarm_sq = gfc_pkg::ALARM_DIST_RST;
    field_offset = gfc_pkg::POS_OFFSET_RST;
    frame_pos = 0;
    recent_chars = '0;
    synced = 1'b0;
    clear_fields();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed frames at reset settings
    queue_marker(0, 0);
    add_frame(FRAME_NINES, 0);
    add_frame(FRAME_ZEROS, 0);
    add_frame(FRAME_BAD_DIGIT, 30);
    queue_marker(0, 0);
    add_frame(FRAME_SHORT, 0);
    add_frame(FRAME_NOISE, 0);

    for (int p = 0; p < PHASES; p++) begin
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clk);
      lat_cfg = gfc_pkg::LAT_W'($urandom_range(0, 900000000));
      lon_cfg = gfc_pkg::LON_W'($urandom_range(0, 1800000000));
      alarm_cfg = gfc_pkg::DIST_W'({$urandom, $urandom} >> $urandom_range(2, 24));
      offset_cfg = gfc_pkg::POS_W'($urandom_range(0, 12));
      case (p)
        0: begin
          lat_cfg = '0;
          lon_cfg = '0;
          alarm_cfg = '0;
          offset_cfg = '0;
        end
        1: begin
          lat_cfg = gfc_pkg::LAT_W'(900000000);
          lon_cfg = gfc_pkg::LON_W'(1800000000);
          alarm_cfg = '1;
        end
        3: offset_cfg = gfc_pkg::POS_W'(40);
        6: offset_cfg = '0;
        default: ;
      endcase
      write_reg(gfc_pkg::REG_HOME_LAT, gfc_pkg::CFG_W'(lat_cfg));
      write_reg(gfc_pkg::REG_HOME_LON, gfc_pkg::CFG_W'(lon_cfg));
      write_reg(gfc_pkg::REG_ALARM_DIST, gfc_pkg::CFG_W'(alarm_cfg));
      write_reg(gfc_pkg::REG_POS_OFFSET, gfc_pkg::CFG_W'(offset_cfg));
      @(posedge clk);
      cfg_we <= 1'b0;
      send_idle_pct = send_idle_by_mode[p % 4];
      recv_stall_pct = recv_stall_by_mode[p % 4];

      start = chars_queued;
      frames = 0;
      while (chars_queued - start < 70 || frames < 2) begin
        pick = $urandom_range(99);
        if (pick < 65) add_frame(FRAME_RANDOM, 5);
        else if (pick < 75) add_frame(FRAME_BAD_DIGIT, 5);
        else if (pick < 85) add_frame(FRAME_SHORT, 5);
        else if (pick < 92) add_frame(FRAME_NOISE, 0);
        else if (pick < 96) add_frame(FRAME_NINES, 0);
        else add_frame(FRAME_ZEROS, 0);
        frames++;
        if ($urandom_range(19) == 0) wait_for_results();
      end
    end

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("gps_frame_geofence_checker_top test passed");
    end else begin
      $display("gps_frame_geofence_checker_top test failed");
    end
    $finish;
  end

endmodule
